// File: rtl/tds_pkg.sv
`default_nettype none
// shared types and constants for the tick delay scheduler
package tds_pkg;

  localparam int ID_W   = 8;
  localparam int AMT_W  = 32;
  localparam int TICK_W = 64;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_TIME  = 2'd1,
    KIND_DELAY = 2'd2,
    KIND_UNTIL = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    RK_TIME     = 2'd0,
    RK_WAKE     = 2'd1,
    RK_TOO_LATE = 2'd2,
    RK_FULL     = 2'd3
  } reply_kind_t;

  typedef enum logic [1:0] {
    OP_REPLY = 2'd0,
    OP_ENQ   = 2'd1,
    OP_TICK  = 2'd2
  } op_code_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   client_id;
    logic [AMT_W-1:0]  amount;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   reply_to;
    logic [1:0]        reply_kind;
    logic [TICK_W-1:0] tick_value;
    logic              last;
  } result_t;

  typedef struct packed {
    op_code_t          code;
    logic [ID_W-1:0]   client;
    reply_kind_t       rkind;
    logic [TICK_W-1:0] value;
  } op_t;

endpackage
`default_nettype wire

// File: rtl/tick_delay_scheduler.sv
`default_nettype none
// tick delay scheduler top level
//
// Commands enter on cmd, taken on a clock edge with start high and busy low.
// kind selects tick, time query, relative delay or delay until an absolute tick.
// Results leave on result, valid for one cycle while result_strobe is high;
// the receiver takes every result and cannot stall the block.
// A front end keeps the 64-bit tick count, answers the classification of each
// command and places an op in a two-entry queue; busy is high while it is full.
// The back end takes one op at a time from the queue:
//   time query, too_late and table_full replies: one result
//   accepted delay: no result
//   tick: wakes come out during a scan of one slot per cycle from the highest
//         slot down
// The last result caused by a command carries last; a tick with no due client
// gives no result. Commands are taken back to back until the queue fills.
// Reset clears the tick count, frees every slot and empties the queue; the
// block takes commands in the first cycle after reset.
module tick_delay_scheduler #(
  parameter int SLOTS          = 16,
  parameter int CLIENT_ID_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tds_pkg::cmd_t    cmd,
  output tds_pkg::result_t      result,
  output logic                  result_strobe
);

  logic         push;
  logic         pop;
  logic         empty;
  tds_pkg::op_t op_in;
  tds_pkg::op_t op_head;

  tds_front #(
    .CLIENT_ID_BITS(CLIENT_ID_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .full  (busy),
    .cmd   (cmd),
    .push  (push),
    .op    (op_in)
  );

  tds_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (op_in),
    .full  (busy),
    .pop   (pop),
    .dout  (op_head),
    .empty (empty)
  );

  tds_back #(
    .SLOTS          (SLOTS),
    .CLIENT_ID_BITS (CLIENT_ID_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (op_head),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .result_strobe (result_strobe)
  );

  a_single_reply_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (result.reply_kind != tds_pkg::RK_WAKE) |-> result.last)
    else $error("non-wake reply without last");

  a_error_zero_tick: assert property (@(posedge clk) disable iff (rst)
    result_strobe && ((result.reply_kind == tds_pkg::RK_TOO_LATE) ||
                      (result.reply_kind == tds_pkg::RK_FULL))
    |-> (result.tick_value == '0))
    else $error("error reply with nonzero tick value");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("queue filled without a transfer");

endmodule
`default_nettype wire

// File: rtl/tds_front.sv
`default_nettype none
// command front end: owns the tick count and turns commands into queue ops
module tds_front #(
  parameter int CLIENT_ID_BITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           full,
  input  wire tds_pkg::cmd_t  cmd,
  output logic                push,
  output tds_pkg::op_t        op
);

  localparam int IDW = tds_pkg::ID_W;
  localparam int AW  = tds_pkg::AMT_W;
  localparam int TW  = tds_pkg::TICK_W;
  localparam int CB  = (CLIENT_ID_BITS < IDW) ? CLIENT_ID_BITS : IDW;
  localparam logic [IDW-1:0] CMASK = {IDW{1'b1}} >> (IDW - CB);

  logic [TW-1:0]  count;
  logic [TW-1:0]  count_next;
  logic [TW-1:0]  cnt_inc;
  logic [TW-1:0]  amt_ext;
  logic [TW-1:0]  sum;
  logic           late;
  logic [IDW-1:0] cid;

  always_comb begin
    push    = start && !full;
    cid     = cmd.client_id & CMASK;
    amt_ext = {{(TW-AW){1'b0}}, cmd.amount};
    cnt_inc = count + {{(TW-1){1'b0}}, 1'b1};
    sum     = count + amt_ext;
    late    = amt_ext < count;

    count_next = count;
    op.code    = tds_pkg::OP_REPLY;
    op.client  = cid;
    op.rkind   = tds_pkg::RK_TIME;
    op.value   = count;
    case (cmd.kind)
      tds_pkg::KIND_TICK: begin
        op.code    = tds_pkg::OP_TICK;
        op.rkind   = tds_pkg::RK_WAKE;
        op.value   = cnt_inc;
        count_next = cnt_inc;
      end
      tds_pkg::KIND_TIME: begin
        op.code = tds_pkg::OP_REPLY;
      end
      tds_pkg::KIND_DELAY: begin
        op.code  = tds_pkg::OP_ENQ;
        op.rkind = tds_pkg::RK_FULL;
        op.value = sum;
      end
      tds_pkg::KIND_UNTIL: begin
        if (late) begin
          op.rkind = tds_pkg::RK_TOO_LATE;
          op.value = '0;
        end else begin
          op.code  = tds_pkg::OP_ENQ;
          op.rkind = tds_pkg::RK_FULL;
          op.value = amt_ext;
        end
      end
      default: begin
        op.code = tds_pkg::OP_REPLY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tds_queue.sv
`default_nettype none
// two-entry op queue between front end and back end
module tds_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tds_pkg::op_t  din,
  output logic               full,
  input  wire logic          pop,
  output tds_pkg::op_t       dout,
  output logic               empty
);

  tds_pkg::op_t mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic [1:0]   fill_next;

  always_comb begin
    full  = (fill == 2'd2);
    empty = (fill == 2'd0);
    dout  = mem[rd_ptr];
    case ({push, pop})
      2'b10:   fill_next = fill + 2'd1;
      2'b01:   fill_next = fill - 2'd1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tds_back.sv
`default_nettype none
// back end: slot table, free slot stack and the wake scan
module tds_back #(
  parameter int SLOTS          = 16,
  parameter int CLIENT_ID_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tds_pkg::op_t  head,
  input  wire logic          empty,
  output logic               pop,
  output tds_pkg::result_t   result,
  output logic               result_strobe
);

  localparam int IDW = tds_pkg::ID_W;
  localparam int TW  = tds_pkg::TICK_W;
  localparam int CB  = (CLIENT_ID_BITS < IDW) ? CLIENT_ID_BITS : IDW;
  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW  = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [FW-1:0] FULL_TOP  = FW'(SLOTS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_SCAN  = 5'b00100,
    S_TAIL  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SLOTS-1:0] slot_active;
  logic [CB-1:0]    slot_client  [SLOTS];
  logic [TW-1:0]    slot_release [SLOTS];
  logic [IW-1:0]    stack_mem    [SLOTS];
  logic [SLOTS-1:0] stack_vld;
  logic [FW-1:0]    free_top;

  logic [TW-1:0]    rel_q;
  logic [CB-1:0]    cli_q;
  logic [IW-1:0]    stk_q;
  logic [IW-1:0]    scan_addr;
  logic [IW-1:0]    cmp_idx;
  logic             cmp_vld;
  logic [TW-1:0]    count_q;
  logic [IW-1:0]    alloc_addr;
  logic [CB-1:0]    ins_client;
  logic [TW-1:0]    ins_release;
  logic             pend_vld;
  logic [CB-1:0]    pend_client;

  logic [FW-1:0]    top_dec;
  logic [IW-1:0]    pop_pos;
  logic [IW-1:0]    push_pos;
  logic [IW-1:0]    slot_pick;
  logic             due;
  logic             can_push;

  always_comb begin
    top_dec   = free_top - FW'(1);
    pop_pos   = top_dec[IW-1:0];
    push_pos  = free_top[IW-1:0];
    can_push  = free_top < FULL_TOP;
    // for a never-written stack entry the stack position itself serves as the slot index
    slot_pick = stack_vld[alloc_addr] ? stk_q : alloc_addr;
    due       = cmp_vld && slot_active[cmp_idx] && (count_q >= rel_q);
    pop       = (state == S_IDLE) && !empty;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          case (head.code)
            tds_pkg::OP_ENQ: begin
              if (free_top != '0) begin
                state_next = S_ALLOC;
              end
            end
            tds_pkg::OP_TICK: state_next = S_SCAN;
            default:          state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC: state_next = S_IDLE;
      S_SCAN: begin
        if (scan_addr == '0) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL:  state_next = S_FLUSH;
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_active   <= '0;
      stack_vld     <= '0;
      free_top      <= FULL_TOP;
      cmp_vld       <= 1'b0;
      pend_vld      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= 1'b0;
      cmp_vld       <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (!empty) begin
            case (head.code)
              tds_pkg::OP_REPLY: result_strobe <= 1'b1;
              tds_pkg::OP_ENQ: begin
                if (free_top == '0) begin
                  result_strobe <= 1'b1;
                end else begin
                  free_top <= top_dec;
                end
              end
              default: ;
            endcase
          end
        end
        S_ALLOC: slot_active[slot_pick] <= 1'b1;
        S_FLUSH: begin
          result_strobe <= pend_vld;
          pend_vld      <= 1'b0;
        end
        default: ;
      endcase
      // one wake held back so the final one can carry last
      if (due) begin
        slot_active[cmp_idx] <= 1'b0;
        if (can_push) begin
          stack_vld[push_pos] <= 1'b1;
          free_top            <= free_top + FW'(1);
        end
        result_strobe <= pend_vld;
        pend_vld      <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!empty) begin
          case (head.code)
            tds_pkg::OP_REPLY: begin
              result.reply_to   <= head.client;
              result.reply_kind <= head.rkind;
              result.tick_value <= head.value;
              result.last       <= 1'b1;
            end
            tds_pkg::OP_ENQ: begin
              result.reply_to   <= head.client;
              result.reply_kind <= tds_pkg::RK_FULL;
              result.tick_value <= '0;
              result.last       <= 1'b1;
              ins_client        <= head.client[CB-1:0];
              ins_release       <= head.value;
              alloc_addr        <= pop_pos;
            end
            tds_pkg::OP_TICK: begin
              count_q   <= head.value;
              scan_addr <= LAST_SLOT;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmp_idx <= scan_addr;
        if (scan_addr != '0) begin
          scan_addr <= scan_addr - IW'(1);
        end
      end
      S_FLUSH: begin
        result.reply_to   <= IDW'(pend_client);
        result.reply_kind <= tds_pkg::RK_WAKE;
        result.tick_value <= count_q;
        result.last       <= 1'b1;
      end
      default: ;
    endcase
    if (due) begin
      result.reply_to   <= IDW'(pend_client);
      result.reply_kind <= tds_pkg::RK_WAKE;
      result.tick_value <= count_q;
      result.last       <= 1'b0;
      pend_client       <= cli_q;
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (state == S_ALLOC) begin
      slot_client[slot_pick]  <= ins_client;
      slot_release[slot_pick] <= ins_release;
    end
    rel_q <= slot_release[scan_addr];
    cli_q <= slot_client[scan_addr];
  end

  // free slot stack
  always_ff @(posedge clk) begin
    if (due && can_push) begin
      stack_mem[push_pos] <= cmp_idx;
    end
    stk_q <= stack_mem[pop_pos];
  end

endmodule
`default_nettype wire
